/* sv/jsfe_pkg.sv */
package jsfe_pkg;

   // longest key the configuration registers can hold
   localparam int KEY_CHARS = 16;
   localparam int KEY_MAX_DEFAULT = 16;
   localparam int KEY_LENGTH_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_INDEX_WIDTH = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LOW = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LENGTH = 2'd2;

   // special characters
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COLON = 8'h3A;

   // most result words one text byte can cause
   localparam int MAX_RESULTS = 3;
   localparam int COUNT_WIDTH = $clog2(MAX_RESULTS + 1);

   // result queue, depth is a power of two
   localparam int RESULT_PTR_WIDTH = 3;
   localparam int RESULT_DEPTH = 1 << RESULT_PTR_WIDTH;
   localparam int RESULT_CNT_WIDTH = RESULT_PTR_WIDTH + 1;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_COLON,
      PH_OPEN,
      PH_VALUE,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CHAR      = 2'd0,
      KIND_OK        = 2'd1,
      KIND_NOT_FOUND = 2'd2,
      KIND_MALFORMED = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] value_byte;
      kind_type   result_kind;
      logic       run_end;
   } result_type;

   // words produced by one text byte, slot 0 first
   typedef struct packed {
      logic [COUNT_WIDTH-1:0]             count;
      result_type [MAX_RESULTS-1:0]       slot;
   } bundle_type;

endpackage

/* sv/jsfe_channels.sv */
interface jsfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       text_end;

   modport source (output valid, output text_byte, output text_end, input ready);
   modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

interface jsfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value_byte;
   logic [1:0] result_kind;
   logic       run_end;

   modport source (output valid, output value_byte, output result_kind, output run_end,
                   input ready);
   modport sink (input valid, input value_byte, input result_kind, input run_end,
                 output ready);
endinterface

/* sv/json_string_field_extractor.sv */
// Streams a JSON text in one byte per word on req_chan and returns the string value of the
// first quoted key that matches the csr key (up to KEY_MAX characters, longer lengths are
// clamped), unescaped, one character per word on rsp_chan, followed by done, not-found or
// malformed; run_end marks the last word caused by each text byte. Value characters go out
// before an error can be known, so drop them when a run ends malformed. A byte is accepted
// every cycle while the result queue has room; it passes an input register and the window
// compare and state logic into an eight-word result queue. The result port moves one word
// per cycle while the receiver is ready, so a byte that yields two or three words (an
// unknown escape, an end-of-text report) holds the output longer; the queue absorbs it.
// Write the key registers only while the block is idle.
module json_string_field_extractor #(
   parameter int KEY_MAX = jsfe_pkg::KEY_MAX_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   jsfe_req_if.sink                               req_chan,
   jsfe_rsp_if.source                             rsp_chan,
   input  logic                                   csr_we,
   input  logic [jsfe_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [jsfe_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int CW = jsfe_pkg::RESULT_CNT_WIDTH;
   localparam int SW = CW + 1;

   logic [63:0]                                key_low_ff;
   logic [63:0]                                key_high_ff;
   logic [jsfe_pkg::KEY_LENGTH_WIDTH-1:0]      key_len_ff;

   logic                                       take;
   logic                                       busy;
   logic                                       pop;
   logic [CW-1:0]                              fifo_count;
   logic [SW-1:0]                              need;
   jsfe_pkg::bundle_type                       push;
   jsfe_pkg::result_type                       head;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff <= '0;
         key_high_ff <= '0;
         key_len_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            jsfe_pkg::CSR_KEY_LOW:    key_low_ff <= csr_wdata;
            jsfe_pkg::CSR_KEY_HIGH:   key_high_ff <= csr_wdata;
            jsfe_pkg::CSR_KEY_LENGTH: key_len_ff <= csr_wdata[jsfe_pkg::KEY_LENGTH_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // room for the words of the byte in the input register and of the next byte, worst case each
   always_comb begin
      need = SW'(fifo_count) + SW'(jsfe_pkg::MAX_RESULTS);
      if (busy) begin
         need = need + SW'(jsfe_pkg::MAX_RESULTS);
      end
   end

   assign req_chan.ready = (need <= SW'(jsfe_pkg::RESULT_DEPTH));
   assign take = req_chan.valid && req_chan.ready;

   jsfe_scanner #(
      .KEY_MAX (KEY_MAX)
   ) u_scanner (
      .clock      (clock),
      .reset      (reset),
      .take_valid (take),
      .take_byte  (req_chan.text_byte),
      .take_end   (req_chan.text_end),
      .key_bytes  ({key_high_ff, key_low_ff}),
      .key_length (key_len_ff),
      .busy       (busy),
      .push       (push)
   );

   jsfe_result_fifo u_result_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (fifo_count)
   );

   // result port
   assign rsp_chan.valid = (fifo_count != '0);
   assign rsp_chan.value_byte = head.value_byte;
   assign rsp_chan.result_kind = head.result_kind;
   assign rsp_chan.run_end = head.run_end;
   assign pop = rsp_chan.valid && rsp_chan.ready;

endmodule

/* sv/jsfe_scanner.sv */
module jsfe_scanner #(
   parameter int KEY_MAX = jsfe_pkg::KEY_MAX_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     take_valid,
   input  logic [7:0]                               take_byte,
   input  logic                                     take_end,
   input  logic [8*jsfe_pkg::KEY_CHARS-1:0]         key_bytes,
   input  logic [jsfe_pkg::KEY_LENGTH_WIDTH-1:0]    key_length,
   output logic                                     busy,
   output jsfe_pkg::bundle_type                     push
);

   localparam int LEN_WIDTH = $clog2(KEY_MAX + 1);

   logic                          in_valid_ff;
   logic [7:0]                    in_byte_ff;
   logic                          in_end_ff;

   jsfe_pkg::phase_type           phase_ff;
   jsfe_pkg::phase_type           phase_in;
   // older bytes of the window; the newest byte is the input register
   logic [7:0]                    win_ff [KEY_MAX+1];
   logic [7:0]                    win_in [KEY_MAX+1];
   logic                          pend_ff;
   logic                          pend_in;
   logic                          prev_ff;
   logic                          prev_in;

   logic [7:0]                    shifted [KEY_MAX+2];
   logic [7:0]                    key_char [KEY_MAX];
   logic [LEN_WIDTH-1:0]          key_len_eff;
   logic [KEY_MAX:0]              len_match;
   logic                          window_hit;

   jsfe_pkg::result_type          res [jsfe_pkg::MAX_RESULTS];
   logic [jsfe_pkg::COUNT_WIDTH-1:0] n;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= take_valid;
      end
      in_byte_ff <= take_byte;
      in_end_ff <= take_end;
   end

   assign busy = in_valid_ff;

   // key characters and clamped length
   always_comb begin
      for (int i = 0; i < KEY_MAX; i++) begin
         key_char[i] = key_bytes[8*i +: 8];
      end
      if (32'(key_length) > KEY_MAX) begin
         key_len_eff = LEN_WIDTH'(KEY_MAX);
      end else begin
         key_len_eff = key_length[LEN_WIDTH-1:0];
      end
   end

   // window after shifting in the current byte
   always_comb begin
      shifted[0] = in_byte_ff;
      for (int i = 1; i < KEY_MAX + 2; i++) begin
         shifted[i] = win_ff[i-1];
      end
   end

   // parallel compare for every key length, then pick the configured one
   always_comb begin
      for (int l = 0; l <= KEY_MAX; l++) begin
         len_match[l] = (shifted[l+1] == jsfe_pkg::CH_QUOTE);
         for (int i = 0; i < l; i++) begin
            len_match[l] = len_match[l] && (shifted[l-i] == key_char[i]);
         end
      end
      window_hit = (in_byte_ff == jsfe_pkg::CH_QUOTE) && len_match[key_len_eff];
   end

   // run state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsfe_pkg::PH_SEARCH;
         pend_ff <= 1'b0;
         prev_ff <= 1'b0;
         for (int i = 0; i <= KEY_MAX; i++) begin
            win_ff[i] <= 8'd0;
         end
      end else begin
         phase_ff <= phase_in;
         pend_ff <= pend_in;
         prev_ff <= prev_in;
         win_ff <= win_in;
      end
   end

   // next state and result words
   always_comb begin
      phase_in = phase_ff;
      win_in = win_ff;
      pend_in = pend_ff;
      prev_in = prev_ff;
      n = '0;
      for (int k = 0; k < jsfe_pkg::MAX_RESULTS; k++) begin
         res[k] = '{value_byte: 8'd0, result_kind: jsfe_pkg::KIND_CHAR, run_end: 1'b0};
      end

      if (in_valid_ff) begin
         unique case (phase_ff)
            jsfe_pkg::PH_SEARCH: begin
               for (int i = 0; i <= KEY_MAX; i++) begin
                  win_in[i] = shifted[i];
               end
               if (window_hit) begin
                  phase_in = jsfe_pkg::PH_COLON;
               end
            end
            jsfe_pkg::PH_COLON: begin
               if (in_byte_ff == jsfe_pkg::CH_COLON) begin
                  phase_in = jsfe_pkg::PH_OPEN;
               end
            end
            jsfe_pkg::PH_OPEN: begin
               if (in_byte_ff == jsfe_pkg::CH_QUOTE) begin
                  phase_in = jsfe_pkg::PH_VALUE;
                  pend_in = 1'b0;
                  prev_in = 1'b0;
               end
            end
            jsfe_pkg::PH_VALUE: begin
               priority if (in_byte_ff == jsfe_pkg::CH_QUOTE && !prev_ff) begin
                  // closing quote
                  res[0].result_kind = jsfe_pkg::KIND_OK;
                  n = 2'd1;
                  phase_in = jsfe_pkg::PH_DONE;
               end else if (pend_ff) begin
                  if (in_byte_ff == jsfe_pkg::CH_BACKSLASH ||
                      in_byte_ff == jsfe_pkg::CH_QUOTE) begin
                     res[0].value_byte = in_byte_ff;
                     n = 2'd1;
                  end else begin
                     // unknown escape kept as two characters
                     res[0].value_byte = jsfe_pkg::CH_BACKSLASH;
                     res[1].value_byte = in_byte_ff;
                     n = 2'd2;
                  end
                  pend_in = 1'b0;
               end else if (in_byte_ff == jsfe_pkg::CH_BACKSLASH) begin
                  pend_in = 1'b1;
               end else begin
                  res[0].value_byte = in_byte_ff;
                  n = 2'd1;
               end
               prev_in = (in_byte_ff == jsfe_pkg::CH_BACKSLASH);
            end
            jsfe_pkg::PH_DONE: begin
            end
            default: begin
            end
         endcase

         // end of text: report not-found or malformed unless the value closed, and start a new run
         if (in_end_ff) begin
            if (phase_in == jsfe_pkg::PH_SEARCH) begin
               res[n].result_kind = jsfe_pkg::KIND_NOT_FOUND;
               n = n + 2'd1;
            end else if (phase_in != jsfe_pkg::PH_DONE) begin
               res[n].result_kind = jsfe_pkg::KIND_MALFORMED;
               n = n + 2'd1;
            end
            phase_in = jsfe_pkg::PH_SEARCH;
            pend_in = 1'b0;
            prev_in = 1'b0;
            for (int i = 0; i <= KEY_MAX; i++) begin
               win_in[i] = 8'd0;
            end
         end

         if (n != '0) begin
            res[n - 2'd1].run_end = 1'b1;
         end
      end
   end

   // words handed to the result queue
   always_comb begin
      push.count = n;
      for (int k = 0; k < jsfe_pkg::MAX_RESULTS; k++) begin
         push.slot[k] = res[k];
      end
   end

endmodule

/* sv/jsfe_result_fifo.sv */
module jsfe_result_fifo (
   input  logic                                    clock,
   input  logic                                    reset,
   input  jsfe_pkg::bundle_type                    push,
   input  logic                                    pop,
   output jsfe_pkg::result_type                    head,
   output logic [jsfe_pkg::RESULT_CNT_WIDTH-1:0]   count
);

   localparam int PW = jsfe_pkg::RESULT_PTR_WIDTH;
   localparam int CW = jsfe_pkg::RESULT_CNT_WIDTH;

   jsfe_pkg::result_type mem [jsfe_pkg::RESULT_DEPTH];
   logic [PW-1:0]        wr_ptr_ff;
   logic [PW-1:0]        wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff;
   logic [PW-1:0]        rd_ptr_in;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic [PW-1:0]        wr_addr [jsfe_pkg::MAX_RESULTS];

   // consecutive write slots for one bundle
   always_comb begin
      for (int k = 0; k < jsfe_pkg::MAX_RESULTS; k++) begin
         wr_addr[k] = wr_ptr_ff + PW'(k);
      end
      wr_ptr_in = wr_ptr_ff + PW'(push.count);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in = count_ff + CW'(push.count) - CW'(pop);
   end

   // storage
   always_ff @(posedge clock) begin
      for (int k = 0; k < jsfe_pkg::MAX_RESULTS; k++) begin
         if (jsfe_pkg::COUNT_WIDTH'(k) < push.count) begin
            mem[wr_addr[k]] <= push.slot[k];
         end
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign head = mem[rd_ptr_ff];
   assign count = count_ff;

endmodule

/* test/jsfe_tb_pkg.sv */
`timescale 1ns / 100ps

package jsfe_tb_pkg;
   import jsfe_pkg::*;

   localparam int WINDOW_DEPTH = KEY_MAX_DEFAULT + 2;

   // key search and value unescape model, plus the words still owed by the block
   class json_value_scoreboard;
      logic [CSR_DATA_WIDTH-1:0]   key_low;
      logic [CSR_DATA_WIDTH-1:0]   key_high;
      logic [KEY_LENGTH_WIDTH-1:0] key_length;
      phase_type                   phase;
      logic [7:0]                  window [WINDOW_DEPTH];
      bit                          escape_pending;
      bit                          prev_backslash;
      result_type                  step_words [$];
      result_type                  owed_words [$];
      int                          errors;

      function new();
         key_low = '0;
         key_high = '0;
         key_length = '0;
         errors = 0;
         restart_text();
      endfunction

      // the search and unescape state returns to its reset value between texts; the key stays
      function void restart_text();
         phase = PH_SEARCH;
         foreach (window[i]) window[i] = 8'h00;
         escape_pending = 1'b0;
         prev_backslash = 1'b0;
      endfunction

      function void set_key(logic [63:0] low, logic [63:0] high, logic [4:0] len);
         key_low = low;
         key_high = high;
         key_length = len;
      endfunction

      function int pending();
         return owed_words.size();
      endfunction

      function logic [7:0] key_char(int i);
         if (i < 8) return key_low[8*i +: 8];
         return key_high[8*(i-8) +: 8];
      endfunction

      // newest byte sits in slot 0, so the key reads backwards from the far quote
      function bit key_in_window();
         int len;
         int last;
         int i;
         len = (key_length > KEY_MAX_DEFAULT) ? KEY_MAX_DEFAULT : int'(key_length);
         last = len + 1;
         if (window[0] != CH_QUOTE || window[last] != CH_QUOTE) return 1'b0;
         for (i = 0; i < len; i++) begin
            if (window[last-1-i] != key_char(i)) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void emit(logic [7:0] value, kind_type kind);
         step_words.push_back(result_type'{value, kind, 1'b0});
      endfunction

      // advance the model by one accepted text byte and queue the words it causes
      function void note_text_byte(logic [7:0] b, logic text_end);
         int i;
         step_words.delete();
         case (phase)
            PH_SEARCH: begin
               for (i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
               window[0] = b;
               if (key_in_window()) phase = PH_COLON;
            end
            PH_COLON: begin
               if (b == CH_COLON) phase = PH_OPEN;
            end
            PH_OPEN: begin
               if (b == CH_QUOTE) begin
                  phase = PH_VALUE;
                  escape_pending = 1'b0;
                  prev_backslash = 1'b0;
               end
            end
            PH_VALUE: begin
               // a quote right after any raw backslash never closes the value
               if (b == CH_QUOTE && !prev_backslash) begin
                  emit(8'h00, KIND_OK);
                  phase = PH_DONE;
               end else if (escape_pending) begin
                  if (b == CH_BACKSLASH || b == CH_QUOTE) begin
                     emit(b, KIND_CHAR);
                  end else begin
                     // unknown escape goes out as it came
                     emit(CH_BACKSLASH, KIND_CHAR);
                     emit(b, KIND_CHAR);
                  end
                  escape_pending = 1'b0;
               end else if (b == CH_BACKSLASH) begin
                  escape_pending = 1'b1;
               end else begin
                  emit(b, KIND_CHAR);
               end
               prev_backslash = (b == CH_BACKSLASH);
            end
            default: ;
         endcase
         if (text_end) begin
            if (phase == PH_SEARCH) emit(8'h00, KIND_NOT_FOUND);
            else if (phase != PH_DONE) emit(8'h00, KIND_MALFORMED);
            restart_text();
         end
         if (step_words.size() > 0) step_words[step_words.size()-1].run_end = 1'b1;
         foreach (step_words[i]) owed_words.push_back(step_words[i]);
      endfunction

      function void check_word(result_type got);
         result_type want;
         if (owed_words.size() == 0) begin
            $error("word with nothing owed: value_byte %h result_kind %0d run_end %0d",
                   got.value_byte, got.result_kind, got.run_end);
            errors++;
            return;
         end
         want = owed_words.pop_front();
         if (got.value_byte !== want.value_byte) begin
            $error("value_byte: expected %h, actual %h", want.value_byte, got.value_byte);
            errors++;
         end
         if (got.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, actual %0d", want.result_kind, got.result_kind);
            errors++;
         end
         if (got.run_end !== want.run_end) begin
            $error("run_end: expected %0d, actual %0d", want.run_end, got.run_end);
            errors++;
         end
      endfunction
   endclass

endpackage

/* test/json_string_field_extractor_tb.sv */
`timescale 1ns / 100ps

module json_string_field_extractor_tb;
   import jsfe_pkg::*;
   import jsfe_tb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES = 60;
   localparam int PHASE_BYTES = 16;

   typedef enum int {
      SHAPE_NO_KEY,
      SHAPE_NO_COLON,
      SHAPE_NO_OPEN,
      SHAPE_NO_CLOSE,
      SHAPE_GOOD
   } text_shape_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   jsfe_req_if req_chan ();
   jsfe_rsp_if rsp_chan ();

   json_string_field_extractor uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   json_value_scoreboard sb = new();

   logic [7:0] text_bytes [$];
   int         idle_pct;
   int         stall_pct;
   int         hold_requests;
   int         holds_served;
   int         hold_left;
   int         sent_count;
   int         cycle_count;

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off when one is requested
   initial begin
      holds_served = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_word(result_type'{rsp_chan.value_byte, kind_type'(rsp_chan.result_kind),
                                    rsp_chan.run_end});
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // quotes and colons turn up often so that stray keys and values get tried
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(7))
         0, 1: return CH_QUOTE;
         2: return CH_COLON;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // one text around the current key; a shape other than good drops one piece
   function automatic void build_text(text_shape_type shape, int value_items);
      int         i;
      int         len;
      logic [7:0] b;
      text_bytes.delete();
      repeat ($urandom_range(3)) text_bytes.push_back(noise_byte());
      len = (sb.key_length > KEY_MAX_DEFAULT) ? KEY_MAX_DEFAULT : int'(sb.key_length);
      if (shape != SHAPE_NO_KEY) begin
         text_bytes.push_back(CH_QUOTE);
         for (i = 0; i < len; i++) text_bytes.push_back(sb.key_char(i));
         text_bytes.push_back(CH_QUOTE);
      end
      repeat ($urandom_range(1)) text_bytes.push_back(8'h20);
      if (shape != SHAPE_NO_COLON) text_bytes.push_back(CH_COLON);
      repeat ($urandom_range(1)) text_bytes.push_back(8'h20);
      if (shape != SHAPE_NO_OPEN) text_bytes.push_back(CH_QUOTE);
      for (i = 0; i < value_items; i++) begin
         case ($urandom_range(9))
            0: begin
               text_bytes.push_back(CH_BACKSLASH);
               text_bytes.push_back(CH_BACKSLASH);
            end
            1: begin
               text_bytes.push_back(CH_BACKSLASH);
               text_bytes.push_back(CH_QUOTE);
            end
            2: begin
               text_bytes.push_back(CH_BACKSLASH);
               text_bytes.push_back(8'($urandom_range(255)));
            end
            3: begin
               // escaped backslash then a quote that still does not close
               text_bytes.push_back(CH_BACKSLASH);
               text_bytes.push_back(CH_BACKSLASH);
               text_bytes.push_back(CH_QUOTE);
            end
            default: begin
               b = 8'($urandom_range(255));
               if (b == CH_QUOTE || b == CH_BACKSLASH) b = 8'h41;
               text_bytes.push_back(b);
            end
         endcase
      end
      if (shape != SHAPE_NO_CLOSE) text_bytes.push_back(CH_QUOTE);
      repeat ($urandom_range(2)) text_bytes.push_back(noise_byte());
   endfunction

   task automatic send_byte(logic [7:0] b, logic text_end);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.text_byte <= b;
      req_chan.text_end <= text_end;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sb.note_text_byte(b, text_end);
      sent_count++;
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text_bytes.size(); i++)
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   // stop offering words until every owed word is back and the pipeline is empty
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_key(logic [63:0] low, logic [63:0] high, logic [4:0] len);
      csr_we <= 1'b1;
      csr_index <= CSR_KEY_LOW;
      csr_wdata <= low;
      @(posedge clock);
      csr_index <= CSR_KEY_HIGH;
      csr_wdata <= high;
      @(posedge clock);
      csr_index <= CSR_KEY_LENGTH;
      csr_wdata <= 64'(len);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_key(low, high, len);
   endtask

   // mostly short keys, sometimes empty, full or over length
   task automatic load_random_key();
      logic [4:0] len;
      case ($urandom_range(9))
         0: len = 5'd0;
         1: len = 5'd16;
         2: len = 5'($urandom_range(31, 17));
         default: len = 5'($urandom_range(8, 1));
      endcase
      load_key(rand64(), rand64(), len);
   endtask

   initial begin
      int ph;
      int phase_start;
      int r;

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_KEY_LOW;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.text_byte <= 8'h00;
      req_chan.text_end <= 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      hold_requests = 0;
      sent_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty key after reset: zero and all-ones bytes, escapes, bytes after the close
      text_bytes = '{CH_QUOTE, CH_QUOTE, CH_COLON, CH_QUOTE, 8'h00, 8'hFF,
                     CH_BACKSLASH, CH_QUOTE, CH_BACKSLASH, 8'h6E,
                     CH_BACKSLASH, CH_BACKSLASH, CH_QUOTE, CH_QUOTE, 8'h78};
      send_text();
      // key missing
      text_bytes = '{8'h00};
      send_text();
      // text ends on a pending backslash
      text_bytes = '{CH_QUOTE, CH_QUOTE, CH_COLON, CH_QUOTE, CH_BACKSLASH};
      send_text();
      // text ends before the colon
      text_bytes = '{CH_QUOTE, CH_QUOTE};
      send_text();

      // random texts over four idling settings
      for (ph = 0; ph < 4; ph++) begin
         wait_drained();
         if (ph == 0) load_key('1, '1, 5'd31);
         else if (ph == 2) load_key('0, '0, 5'd16);
         else load_random_key();
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 82; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 82; end
            default: begin idle_pct = 29; stall_pct = 29; end
         endcase
         phase_start = sent_count;
         while (sent_count - phase_start < PHASE_BYTES) begin
            if ($urandom_range(4) == 0) begin
               wait_drained();
               load_random_key();
            end
            r = $urandom_range(9);
            build_text(r < 4 ? text_shape_type'(r) : SHAPE_GOOD, $urandom_range(6));
            send_text();
         end
      end

      // long value against a receiver that holds off, so the result queue backs up
      wait_drained();
      idle_pct = 0;
      stall_pct = 0;
      load_key(64'h6261, rand64(), 5'd2);
      hold_requests++;
      build_text(SHAPE_GOOD, 30);
      send_text();

      wait_drained();
      if (sb.errors == 0 && sb.pending() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
